// ===== src/bdd_pkg.sv =====
// Shared constants, types and helpers for the bit-packed dictionary decoder.
// Used by bdd_lane, bdd_merge and bitpacked_dictionary_decoder_top; no dependencies.
`default_nettype none

package bdd_pkg;

  localparam int DICT_ADDR_BITS     = 12;
  localparam int MAX_CODES_PER_WORD = 8;

  localparam int DICT_DEPTH  = 1 << DICT_ADDR_BITS;
  localparam int LANE_IDX_W  = (MAX_CODES_PER_WORD > 1) ? $clog2(MAX_CODES_PER_WORD) : 1;
  localparam int CNT_W       = $clog2(MAX_CODES_PER_WORD + 1);
  localparam int WORD_W      = 16;
  localparam int NARROW_W    = 8;
  localparam int NARROW_FS   = 4;
  localparam int FS_W        = 5;
  localparam int FS_MAX      = 16;
  localparam int REQ_W       = 4;
  localparam int INDEX_IN_W  = 12;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 32;
  localparam int FS_RESET    = 8;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic REG_FIELD_SIZE = 1'b0;
  localparam logic REG_START_POS  = 1'b1;

  // One decode job as handed from the lanes to the merging stage.
  typedef struct packed {
    logic [MAX_CODES_PER_WORD-1:0][DICT_ADDR_BITS-1:0] addr;
    logic [MAX_CODES_PER_WORD-1:0]                     oob;
    logic [CNT_W-1:0]                                  cnt;
  } job_t;

  // Codes per word for an effective field size, clipped to the lane count,
  // then the requested count clipped to that.
  function automatic logic [CNT_W-1:0] sat_count(input logic [FS_W-1:0] fs,
                                                 input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] cap;
    cap = 4'd1;
    case (fs) inside
      5'd1:          cap = 4'd8;
      5'd2:          cap = 4'd4;
      [5'd3:5'd4]:   cap = 4'd2;
      5'd5:          cap = 4'd3;
      [5'd6:5'd8]:   cap = 4'd2;
      default:       cap = 4'd1;
    endcase
    if (cap > REQ_W'(MAX_CODES_PER_WORD)) begin
      cap = REQ_W'(MAX_CODES_PER_WORD);
    end
    return (req > cap) ? CNT_W'(cap) : CNT_W'(req);
  endfunction

endpackage

`default_nettype wire

// ===== src/bdd_lane.sv =====
// One extraction lane: pulls the code of its slot out of the packed word.
// Depends on bdd_pkg.
`default_nettype none

module bdd_lane (
  input  wire logic [bdd_pkg::WORD_W-1:0]         word_i,
  input  wire logic [bdd_pkg::FS_W-1:0]           fs_i,
  input  wire logic [bdd_pkg::LANE_IDX_W-1:0]     lane_i,
  output logic      [bdd_pkg::DICT_ADDR_BITS-1:0] addr_o,
  output logic                                    oob_o
);

  localparam int SHIFT_W = bdd_pkg::LANE_IDX_W + bdd_pkg::FS_W;

  logic [SHIFT_W-1:0]            shift;
  logic [bdd_pkg::WORD_W:0]      mask;
  logic [bdd_pkg::WORD_W-1:0]    code;

  always_comb begin
    shift  = SHIFT_W'(lane_i) * SHIFT_W'(fs_i);
    mask   = ((bdd_pkg::WORD_W+1)'(1) << fs_i) - (bdd_pkg::WORD_W+1)'(1);
    code   = (word_i >> shift) & mask[bdd_pkg::WORD_W-1:0];
    // codes past the store read as zero downstream
    oob_o  = |(code >> bdd_pkg::DICT_ADDR_BITS);
    addr_o = code[bdd_pkg::DICT_ADDR_BITS-1:0];
  end

endmodule

`default_nettype wire

// ===== src/bdd_merge.sv =====
// Merging stage: holds a decoded job, looks its codes up in the dictionary one per
// cycle while the output is not stalled, and streams values with positions. Owns the
// dictionary memory. Depends on bdd_pkg.
`default_nettype none

module bdd_merge (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                job_valid_i,
  input  wire bdd_pkg::job_t                       job_i,
  input  wire logic                                load_en_i,
  input  wire logic [bdd_pkg::DICT_ADDR_BITS-1:0]  load_addr_i,
  input  wire logic [bdd_pkg::DATA_W-1:0]          load_data_i,
  input  wire logic [bdd_pkg::POS_W-1:0]           start_position_i,
  input  wire logic                                count_clr_i,
  output logic                                     take_ok_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [bdd_pkg::DATA_W-1:0]          value_o,
  output logic      [bdd_pkg::POS_W-1:0]           position_o,
  output logic                                     last_o
);

  localparam int AW = bdd_pkg::DICT_ADDR_BITS;

  logic [bdd_pkg::DATA_W-1:0] dict_mem [bdd_pkg::DICT_DEPTH];

  logic [AW:0] clr_q, clr_d;
  logic        clr_done;

  bdd_pkg::job_t                      job_q;
  logic [bdd_pkg::CNT_W-1:0]          rem_q, rem_d;
  logic [bdd_pkg::LANE_IDX_W-1:0]     idx_q, idx_d;
  logic [bdd_pkg::POS_W-1:0]          emit_q, emit_d;

  logic                      s1_valid_q, s1_valid_d;
  logic [bdd_pkg::DATA_W-1:0] rdata_q;
  logic                      s1_oob_q;
  logic [bdd_pkg::POS_W-1:0] s1_pos_q;
  logic                      s1_last_q;

  logic                      out_valid_q, out_valid_d;
  logic [bdd_pkg::DATA_W-1:0] out_value_q;
  logic [bdd_pkg::POS_W-1:0] out_pos_q;
  logic                      out_last_q;

  logic          out_free, s1_move, s1_free, issue;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [bdd_pkg::DATA_W-1:0] wr_data;

  assign clr_done = clr_q[AW];
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || out_free;
  assign issue    = (rem_q != '0) && s1_free;
  // take a new item only once the current job issues its final lookup
  assign take_ok_o = clr_done &&
                     ((rem_q == '0) || ((rem_q == bdd_pkg::CNT_W'(1)) && issue));

  always_comb begin
    clr_d = clr_done ? clr_q : clr_q + (AW+1)'(1);
    rem_d = rem_q;
    idx_d = idx_q;
    if (job_valid_i) begin
      rem_d = job_i.cnt;
      idx_d = '0;
    end else if (issue) begin
      rem_d = rem_q - bdd_pkg::CNT_W'(1);
      idx_d = idx_q + bdd_pkg::LANE_IDX_W'(1);
    end
    emit_d = emit_q;
    if (count_clr_i) begin
      emit_d = '0;
    end else if (issue) begin
      emit_d = emit_q + bdd_pkg::POS_W'(1);
    end
    s1_valid_d  = issue || (s1_valid_q && !out_free);
    out_valid_d = s1_move || (out_valid_q && !out_ready_i);
    wr_en   = !clr_done || load_en_i;
    wr_addr = clr_done ? load_addr_i : clr_q[AW-1:0];
    wr_data = clr_done ? load_data_i : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      emit_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      emit_q      <= emit_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) begin
      job_q <= job_i;
    end
    if (issue) begin
      s1_oob_q  <= job_q.oob[idx_q];
      s1_pos_q  <= start_position_i + emit_q;
      s1_last_q <= (rem_q == bdd_pkg::CNT_W'(1));
    end
    if (s1_move) begin
      out_value_q <= s1_oob_q ? '0 : rdata_q;
      out_pos_q   <= s1_pos_q;
      out_last_q  <= s1_last_q;
    end
  end

  // Read before write: a lookup and a later load to the same entry in one cycle
  // see the old value.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dict_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= dict_mem[job_q.addr[idx_q]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== src/bitpacked_dictionary_decoder_top.sv =====
// Top level of the bit-packed dictionary decoder: configuration registers,
// extraction lanes and the merging stage. Depends on bdd_pkg, bdd_lane, bdd_merge.
// A decode word passes the job register, lookup stage and output register before its
// first value is valid. One value per cycle while the output is not stalled; a word of n
// codes takes n lookups. Reset: a clearing pass zeroes the dictionary, input ready stays
// low meanwhile; configuration writes are taken at any time.
`default_nettype none

module bitpacked_dictionary_decoder_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         command_i,
  input  wire logic [11:0]  dict_index_i,
  input  wire logic [31:0]  dict_value_i,
  input  wire logic [15:0]  packed_word_i,
  input  wire logic [3:0]   code_count_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [31:0]       value_o,
  output logic [31:0]       position_o,
  output logic              last_o
);

  localparam int AW = bdd_pkg::DICT_ADDR_BITS;

  logic [bdd_pkg::FS_W-1:0]   field_size_q, field_size_d;
  logic [bdd_pkg::POS_W-1:0]  start_pos_q, start_pos_d;
  logic                       count_clr;

  logic [bdd_pkg::FS_W-1:0]   fs_eff;
  logic [bdd_pkg::WORD_W-1:0] word;
  bdd_pkg::job_t              job;
  logic                       accepted, job_valid, load_en, take_ok;
  logic [bdd_pkg::WORD_W-1:0] idx_ext;

  always_comb begin
    field_size_d = field_size_q;
    start_pos_d  = start_pos_q;
    count_clr    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bdd_pkg::REG_FIELD_SIZE: field_size_d = cfg_data_i[bdd_pkg::FS_W-1:0];
        bdd_pkg::REG_START_POS: begin
          start_pos_d = cfg_data_i;
          count_clr   = 1'b1;
        end
        default: field_size_d = field_size_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_size_q <= bdd_pkg::FS_W'(bdd_pkg::FS_RESET);
      start_pos_q  <= '0;
    end else begin
      field_size_q <= field_size_d;
      start_pos_q  <= start_pos_d;
    end
  end

  always_comb begin
    if (field_size_q == '0) begin
      fs_eff = bdd_pkg::FS_W'(1);
    end else if (field_size_q > bdd_pkg::FS_W'(bdd_pkg::FS_MAX)) begin
      fs_eff = bdd_pkg::FS_W'(bdd_pkg::FS_MAX);
    end else begin
      fs_eff = field_size_q;
    end
    // narrow fields use only the low byte
    if (fs_eff <= bdd_pkg::FS_W'(bdd_pkg::NARROW_FS)) begin
      word = {{(bdd_pkg::WORD_W-bdd_pkg::NARROW_W){1'b0}},
              packed_word_i[bdd_pkg::NARROW_W-1:0]};
    end else begin
      word = packed_word_i;
    end
  end

  for (genvar k = 0; k < bdd_pkg::MAX_CODES_PER_WORD; k++) begin : g_lane
    bdd_lane u_lane (
      .word_i (word),
      .fs_i   (fs_eff),
      .lane_i (bdd_pkg::LANE_IDX_W'(k)),
      .addr_o (job.addr[k]),
      .oob_o  (job.oob[k])
    );
  end

  assign job.cnt = bdd_pkg::sat_count(fs_eff, code_count_i);

  assign in_ready_o = take_ok;
  assign accepted   = in_valid_i && take_ok;
  assign job_valid  = accepted && (command_i == bdd_pkg::CMD_DECODE);
  // drop loads whose index lies past the store
  assign idx_ext    = bdd_pkg::WORD_W'(dict_index_i);
  assign load_en    = accepted && (command_i == bdd_pkg::CMD_LOAD) &&
                      ((idx_ext >> AW) == '0);

  bdd_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (job),
    .load_en_i        (load_en),
    .load_addr_i      (idx_ext[AW-1:0]),
    .load_data_i      (dict_value_i),
    .start_position_i (start_pos_q),
    .count_clr_i      (count_clr),
    .take_ok_o        (take_ok),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .position_o       (position_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
